@@ hdl/hhm_pkg.sv @@
// shared types, constants and hash functions of the hopscotch hash map
package hhm_pkg;

    // table geometry: offsets and slot numbers are one byte wide
    localparam int CAPACITY = 256;
    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W = SLOT_W + 1;

    // defaults for the top level parameters
    localparam int KEY_BYTES_DEF = 8;
    localparam int VALUE_BITS_DEF = 32;

    // link and limit constants
    localparam logic [7:0] NO_LINK = 8'hFF;
    localparam logic [7:0] OFFSET_CEIL = 8'd254;
    localparam logic [7:0] LIMIT_FLOOR = 8'd4;
    localparam logic [7:0] LIMIT_RESET = 8'd25;
    localparam logic [CNT_W-1:0] WALK_BOUND = CNT_W'(CAPACITY);

    typedef logic [SLOT_W-1:0] slot_idx_t;

    typedef enum logic [1:0] {
        OP_GET = 2'd0,
        OP_NEW = 2'd1,
        OP_PUT = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_PRESENT = 2'd2,
        STAT_FULL = 2'd3
    } status_t;

    // one key byte of the one-at-a-time hash
    function automatic logic [31:0] oaat_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] h1;
        logic [31:0] h2;
        h1 = h + {24'd0, b};
        h2 = h1 + (h1 << 10);
        return h2 ^ (h2 >> 6);
    endfunction

    // final avalanche of the one-at-a-time hash
    function automatic logic [31:0] oaat_final(input logic [31:0] h);
        logic [31:0] h1;
        logic [31:0] h2;
        h1 = h + (h << 3);
        h2 = h1 ^ (h1 >> 11);
        return h2 + (h2 << 15);
    endfunction

endpackage

@@ hdl/hhm_ram.sv @@
// generic single write port ram with registered read
module hhm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/hhm_front.sv @@
// front end: accepts requests and computes the home bucket hash
module hhm_front #(
    parameter int KEY_BYTES = hhm_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = hhm_pkg::VALUE_BITS_DEF,
    parameter int QW = 2 + 8 * KEY_BYTES + VALUE_BITS + hhm_pkg::SLOT_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    op,
    input  logic [63:0]   key,
    input  logic [31:0]   value,
    input  logic          clearing,
    output logic          push_valid,
    input  logic          push_ready,
    output logic [QW-1:0] push_data
);

    localparam int KEYW = 8 * KEY_BYTES;
    localparam int CW = $clog2(KEY_BYTES + 1);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_HASH = 4'b0010,
        F_FIN  = 4'b0100,
        F_PUSH = 4'b1000
    } fstate_t;

    fstate_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [31:0] hash_reg, hash_next;
    logic [1:0] op_reg, op_next;
    logic [KEYW-1:0] key_reg, key_next;
    logic [KEYW-1:0] shift_reg, shift_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;

    assign in_ready = (state_reg == F_IDLE) && !clearing;
    assign push_valid = (state_reg == F_PUSH);
    assign push_data = {op_reg, key_reg, val_reg, hash_reg[hhm_pkg::SLOT_W-1:0]};

    // request capture and byte-serial hashing
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        hash_next = hash_reg;
        op_next = op_reg;
        key_next = key_reg;
        shift_next = shift_reg;
        val_next = val_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next = op;
                    key_next = KEYW'(key);
                    shift_next = KEYW'(key);
                    val_next = VALUE_BITS'(value);
                    hash_next = 32'd0;
                    cnt_next = '0;
                    state_next = F_HASH;
                end
            end
            F_HASH:
            begin
                hash_next = hhm_pkg::oaat_step(hash_reg, shift_reg[7:0]);
                shift_next = shift_reg >> 8;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(KEY_BYTES - 1))
                begin
                    state_next = F_FIN;
                end
            end
            F_FIN:
            begin
                hash_next = hhm_pkg::oaat_final(hash_reg);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        hash_reg <= hash_next;
        op_reg <= op_next;
        key_reg <= key_next;
        shift_reg <= shift_next;
        val_reg <= val_next;
    end

endmodule

@@ hdl/hhm_queue.sv @@
// two entry request queue between front and back
module hhm_queue #(
    parameter int QW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  logic [QW-1:0] push_data,
    output logic          pop_valid,
    input  logic          pop_ready,
    output logic [QW-1:0] pop_data
);

    logic [QW-1:0] entry_reg [2];
    logic [1:0] fill_reg, fill_next;
    logic wr_ptr_reg, rd_ptr_reg;
    logic do_push, do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid = (fill_reg != 2'd0);
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    // fill level
    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/hhm_back.sv @@
// back end: sequencer for lookup, chain maintenance, probing and displacement
module hhm_back #(
    parameter int KEY_BYTES = hhm_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = hhm_pkg::VALUE_BITS_DEF,
    parameter int QW = 2 + 8 * KEY_BYTES + VALUE_BITS + hhm_pkg::SLOT_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    lim,
    input  logic          q_valid,
    output logic          q_pop,
    input  logic [QW-1:0] q_data,
    output logic          clearing,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    status,
    output logic [31:0]   value_out,
    output logic [8:0]    member_count
);

    localparam int KEYW = 8 * KEY_BYTES;
    localparam int VB = VALUE_BITS;
    localparam int POS_VAL = 24;
    localparam int POS_KEY = POS_VAL + VB;
    localparam int POS_USED = POS_KEY + KEYW;
    localparam int SW = POS_USED + 1;
    localparam int AW = hhm_pkg::SLOT_W;
    localparam int CW = hhm_pkg::CNT_W;

    typedef enum logic [25:0] {
        S_CLR       = 26'h1 << 0,
        S_IDLE      = 26'h1 << 1,
        S_F_HEAD    = 26'h1 << 2,
        S_F_HW      = 26'h1 << 3,
        S_F_CHK     = 26'h1 << 4,
        S_F_SLOT    = 26'h1 << 5,
        S_DISP      = 26'h1 << 6,
        S_RMW       = 26'h1 << 7,
        S_UL_HEAD   = 26'h1 << 8,
        S_UL_A      = 26'h1 << 9,
        S_UL_B      = 26'h1 << 10,
        S_UL_CLR    = 26'h1 << 11,
        S_LK_HEAD   = 26'h1 << 12,
        S_LK_DEC    = 26'h1 << 13,
        S_LK_WALK   = 26'h1 << 14,
        S_LK_NXT    = 26'h1 << 15,
        S_LK_WS     = 26'h1 << 16,
        S_INS_PROBE = 26'h1 << 17,
        S_INS_PCHK  = 26'h1 << 18,
        S_INS_LOOP  = 26'h1 << 19,
        S_MV_RD     = 26'h1 << 20,
        S_MV_CHK    = 26'h1 << 21,
        S_MV_LINK   = 26'h1 << 22,
        S_INS_FIN   = 26'h1 << 23,
        S_INS_OK    = 26'h1 << 24,
        S_DONE      = 26'h1 << 25
    } bstate_t;

    // memory ports
    logic slot_we;
    logic [AW-1:0] slot_waddr, slot_raddr;
    logic [SW-1:0] slot_wdata, slot_rdata;
    logic head_we;
    logic [AW-1:0] head_waddr, head_raddr;
    logic [7:0] head_wdata, head_rdata;

    // control registers
    bstate_t state_reg, state_next;
    bstate_t sub_ret_reg, sub_ret_next;
    bstate_t rmw_ret_reg, rmw_ret_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] count_reg, count_next;
    logic out_valid_reg, out_valid_next;
    logic [CW-1:0] out_count_reg, out_count_next;

    // payload registers
    logic [1:0] out_status_reg, out_status_next;
    logic [31:0] out_val_reg, out_val_next;
    hhm_pkg::op_t op_reg, op_next;
    logic [KEYW-1:0] key_reg, key_next;
    logic [VB-1:0] val_reg, val_next;
    logic [AW-1:0] home_reg, home_next;
    logic [7:0] off_reg, off_next;
    logic [CW-1:0] walk_reg, walk_next;
    logic [AW-1:0] f_reg, f_next;
    logic [SW-1:0] fword_reg, fword_next;
    logic found_reg, found_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [AW-1:0] u_s_reg, u_s_next;
    logic [7:0] u_hoff_reg, u_hoff_next;
    logic [7:0] u_nx_reg, u_nx_next;
    logic [7:0] u_pv_reg, u_pv_next;
    logic [AW-1:0] lc_reg, lc_next;
    logic [AW-1:0] ls_reg, ls_next;
    logic [7:0] lo_reg, lo_next;
    logic [7:0] lsucc_reg, lsucc_next;
    logic [7:0] lpred_reg, lpred_next;
    logic [AW-1:0] q_reg, q_next;
    logic [KEYW-1:0] pend_key_reg, pend_key_next;
    logic [VB-1:0] pend_val_reg, pend_val_next;
    logic [AW-1:0] rmw_addr_reg, rmw_addr_next;
    logic rmw_succ_reg, rmw_succ_next;
    logic [7:0] rmw_val_reg, rmw_val_next;
    hhm_pkg::status_t res_status_reg, res_status_next;
    logic [VB-1:0] res_val_reg, res_val_next;

    // fields of the slot word just read
    logic rd_used;
    logic [KEYW-1:0] rd_key;
    logic [VB-1:0] rd_val;
    logic [7:0] rd_hoff, rd_succ;

    // address arithmetic
    logic [AW-1:0] u_c;
    logic [AW-1:0] mv_from, mv_c, mv_to;
    logic [7:0] mv_o;
    logic [SW-1:0] clear_word;

    assign rd_used = slot_rdata[POS_USED];
    assign rd_key = slot_rdata[POS_KEY +: KEYW];
    assign rd_val = slot_rdata[POS_VAL +: VB];
    assign rd_hoff = slot_rdata[23:16];
    assign rd_succ = slot_rdata[15:8];

    assign u_c = u_s_reg - u_hoff_reg;
    assign mv_from = home_reg + j_reg[AW-1:0];
    assign mv_c = mv_from - rd_hoff;
    assign mv_to = home_reg + i_reg[AW-1:0];
    assign mv_o = mv_to - mv_c;
    assign clear_word = {1'b0, {KEYW{1'b0}}, {VB{1'b0}},
                         hhm_pkg::NO_LINK, hhm_pkg::NO_LINK, hhm_pkg::NO_LINK};

    assign clearing = (state_reg == S_CLR);
    assign out_valid = out_valid_reg;
    assign status = out_status_reg;
    assign value_out = out_val_reg;
    assign member_count = out_count_reg;

    // slot store: used, key, value, home offset, successor, predecessor
    hhm_ram #(
        .WIDTH (SW),
        .DEPTH (hhm_pkg::CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // chain head offset per home bucket
    hhm_ram #(
        .WIDTH (8),
        .DEPTH (hhm_pkg::CAPACITY)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    // operation sequencer
    always_comb
    begin
        state_next = state_reg;
        sub_ret_next = sub_ret_reg;
        rmw_ret_next = rmw_ret_reg;
        clr_cnt_next = clr_cnt_reg;
        count_next = count_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        out_status_next = out_status_reg;
        out_val_next = out_val_reg;
        op_next = op_reg;
        key_next = key_reg;
        val_next = val_reg;
        home_next = home_reg;
        off_next = off_reg;
        walk_next = walk_reg;
        f_next = f_reg;
        fword_next = fword_reg;
        found_next = found_reg;
        i_next = i_reg;
        j_next = j_reg;
        u_s_next = u_s_reg;
        u_hoff_next = u_hoff_reg;
        u_nx_next = u_nx_reg;
        u_pv_next = u_pv_reg;
        lc_next = lc_reg;
        ls_next = ls_reg;
        lo_next = lo_reg;
        lsucc_next = lsucc_reg;
        lpred_next = lpred_reg;
        q_next = q_reg;
        pend_key_next = pend_key_reg;
        pend_val_next = pend_val_reg;
        rmw_addr_next = rmw_addr_reg;
        rmw_succ_next = rmw_succ_reg;
        rmw_val_next = rmw_val_reg;
        res_status_next = res_status_reg;
        res_val_next = res_val_reg;
        slot_we = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_raddr = '0;
        head_we = 1'b0;
        head_waddr = '0;
        head_wdata = '0;
        head_raddr = '0;
        q_pop = 1'b0;

        // result register drains independently
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            // clearing pass over both stores
            S_CLR:
            begin
                slot_we = 1'b1;
                slot_waddr = clr_cnt_reg;
                slot_wdata = clear_word;
                head_we = 1'b1;
                head_waddr = clr_cnt_reg;
                head_wdata = hhm_pkg::NO_LINK;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(hhm_pkg::CAPACITY - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    op_next = hhm_pkg::op_t'(q_data[QW-1 -: 2]);
                    key_next = q_data[AW + VB +: KEYW];
                    val_next = q_data[AW +: VB];
                    home_next = q_data[AW-1:0];
                    state_next = S_F_HEAD;
                end
            end
            // chain walk for the key
            S_F_HEAD:
            begin
                head_raddr = home_reg;
                walk_next = '0;
                state_next = S_F_HW;
            end
            S_F_HW:
            begin
                off_next = head_rdata;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (off_reg == hhm_pkg::NO_LINK || walk_reg == hhm_pkg::WALK_BOUND)
                begin
                    found_next = 1'b0;
                    state_next = S_DISP;
                end
                else
                begin
                    slot_raddr = home_reg + off_reg;
                    f_next = home_reg + off_reg;
                    state_next = S_F_SLOT;
                end
            end
            S_F_SLOT:
            begin
                if (rd_used && rd_key == key_reg)
                begin
                    found_next = 1'b1;
                    fword_next = slot_rdata;
                    state_next = S_DISP;
                end
                else
                begin
                    off_next = rd_succ;
                    walk_next = walk_reg + CW'(1);
                    state_next = S_F_CHK;
                end
            end
            // dispatch on operation and lookup result
            S_DISP:
            begin
                res_status_next = hhm_pkg::STAT_OK;
                res_val_next = '0;
                state_next = S_DONE;
                case (op_reg)
                    hhm_pkg::OP_GET:
                    begin
                        if (found_reg)
                        begin
                            res_val_next = fword_reg[POS_VAL +: VB];
                        end
                        else
                        begin
                            res_status_next = hhm_pkg::STAT_NOT_FOUND;
                        end
                    end
                    hhm_pkg::OP_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            u_s_next = f_reg;
                            u_hoff_next = fword_reg[23:16];
                            u_nx_next = fword_reg[15:8];
                            u_pv_next = fword_reg[7:0];
                            sub_ret_next = S_DONE;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CW'(1);
                            end
                            state_next = S_UL_HEAD;
                        end
                        else
                        begin
                            res_status_next = hhm_pkg::STAT_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        if (found_reg)
                        begin
                            if (op_reg == hhm_pkg::OP_NEW)
                            begin
                                res_status_next = hhm_pkg::STAT_PRESENT;
                                res_val_next = fword_reg[POS_VAL +: VB];
                            end
                            else
                            begin
                                slot_we = 1'b1;
                                slot_waddr = f_reg;
                                slot_wdata = fword_reg;
                                slot_wdata[POS_VAL +: VB] = val_reg;
                                res_val_next = val_reg;
                            end
                        end
                        else if (count_reg >= CW'(hhm_pkg::CAPACITY))
                        begin
                            res_status_next = hhm_pkg::STAT_FULL;
                        end
                        else
                        begin
                            i_next = '0;
                            state_next = S_INS_PROBE;
                        end
                    end
                endcase
            end
            // read-modify-write of one link field
            S_RMW:
            begin
                slot_we = 1'b1;
                slot_waddr = rmw_addr_reg;
                slot_wdata = slot_rdata;
                if (rmw_succ_reg)
                begin
                    slot_wdata[15:8] = rmw_val_reg;
                end
                else
                begin
                    slot_wdata[7:0] = rmw_val_reg;
                end
                state_next = rmw_ret_reg;
            end
            // unlink a slot from its chain
            S_UL_HEAD:
            begin
                head_raddr = u_c;
                state_next = S_UL_A;
            end
            S_UL_A:
            begin
                if (head_rdata == u_hoff_reg)
                begin
                    head_we = 1'b1;
                    head_waddr = u_c;
                    head_wdata = u_nx_reg;
                    state_next = S_UL_B;
                end
                else
                begin
                    slot_raddr = u_c + u_pv_reg;
                    rmw_addr_next = u_c + u_pv_reg;
                    rmw_succ_next = 1'b1;
                    rmw_val_next = u_nx_reg;
                    rmw_ret_next = S_UL_B;
                    state_next = S_RMW;
                end
            end
            S_UL_B:
            begin
                if (u_nx_reg != hhm_pkg::NO_LINK)
                begin
                    slot_raddr = u_c + u_nx_reg;
                    rmw_addr_next = u_c + u_nx_reg;
                    rmw_succ_next = 1'b0;
                    rmw_val_next = u_pv_reg;
                    rmw_ret_next = S_UL_CLR;
                    state_next = S_RMW;
                end
                else
                begin
                    state_next = S_UL_CLR;
                end
            end
            S_UL_CLR:
            begin
                slot_we = 1'b1;
                slot_waddr = u_s_reg;
                slot_wdata = clear_word;
                state_next = sub_ret_reg;
            end
            // link a slot into a sorted chain
            S_LK_HEAD:
            begin
                head_raddr = lc_reg;
                state_next = S_LK_DEC;
            end
            S_LK_DEC:
            begin
                if (head_rdata == hhm_pkg::NO_LINK)
                begin
                    head_we = 1'b1;
                    head_waddr = lc_reg;
                    head_wdata = lo_reg;
                    lsucc_next = hhm_pkg::NO_LINK;
                    lpred_next = hhm_pkg::NO_LINK;
                    state_next = S_LK_WS;
                end
                else if (lo_reg < head_rdata)
                begin
                    // nearer than the current head: new head
                    head_we = 1'b1;
                    head_waddr = lc_reg;
                    head_wdata = lo_reg;
                    lsucc_next = head_rdata;
                    lpred_next = hhm_pkg::NO_LINK;
                    slot_raddr = lc_reg + head_rdata;
                    rmw_addr_next = lc_reg + head_rdata;
                    rmw_succ_next = 1'b0;
                    rmw_val_next = lo_reg;
                    rmw_ret_next = S_LK_WS;
                    state_next = S_RMW;
                end
                else
                begin
                    slot_raddr = lc_reg + head_rdata;
                    q_next = lc_reg + head_rdata;
                    walk_next = '0;
                    state_next = S_LK_WALK;
                end
            end
            S_LK_WALK:
            begin
                if (rd_succ != hhm_pkg::NO_LINK && rd_succ < lo_reg &&
                    walk_reg != hhm_pkg::WALK_BOUND)
                begin
                    slot_raddr = lc_reg + rd_succ;
                    q_next = lc_reg + rd_succ;
                    walk_next = walk_reg + CW'(1);
                end
                else
                begin
                    lsucc_next = rd_succ;
                    lpred_next = rd_hoff;
                    slot_we = 1'b1;
                    slot_waddr = q_reg;
                    slot_wdata = slot_rdata;
                    slot_wdata[15:8] = lo_reg;
                    state_next = S_LK_NXT;
                end
            end
            S_LK_NXT:
            begin
                if (lsucc_reg != hhm_pkg::NO_LINK)
                begin
                    slot_raddr = lc_reg + lsucc_reg;
                    rmw_addr_next = lc_reg + lsucc_reg;
                    rmw_succ_next = 1'b0;
                    rmw_val_next = lo_reg;
                    rmw_ret_next = S_LK_WS;
                    state_next = S_RMW;
                end
                else
                begin
                    state_next = S_LK_WS;
                end
            end
            S_LK_WS:
            begin
                slot_we = 1'b1;
                slot_waddr = ls_reg;
                slot_wdata = {1'b1, pend_key_reg, pend_val_reg, lo_reg, lsucc_reg, lpred_reg};
                state_next = sub_ret_reg;
            end
            // linear probe for a free slot
            S_INS_PROBE:
            begin
                if (i_reg == CW'(hhm_pkg::CAPACITY))
                begin
                    res_status_next = hhm_pkg::STAT_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    slot_raddr = home_reg + i_reg[AW-1:0];
                    state_next = S_INS_PCHK;
                end
            end
            S_INS_PCHK:
            begin
                if (!rd_used)
                begin
                    state_next = S_INS_LOOP;
                end
                else
                begin
                    i_next = i_reg + CW'(1);
                    state_next = S_INS_PROBE;
                end
            end
            // displacement toward home
            S_INS_LOOP:
            begin
                if (i_reg >= CW'(lim))
                begin
                    j_next = i_reg;
                    state_next = S_MV_RD;
                end
                else
                begin
                    state_next = S_INS_FIN;
                end
            end
            S_MV_RD:
            begin
                if (j_reg == '0)
                begin
                    res_status_next = hhm_pkg::STAT_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    j_next = j_reg - CW'(1);
                    slot_raddr = home_reg + AW'(j_reg - CW'(1));
                    state_next = S_MV_CHK;
                end
            end
            S_MV_CHK:
            begin
                if (mv_o >= hhm_pkg::OFFSET_CEIL)
                begin
                    state_next = S_MV_RD;
                end
                else
                begin
                    pend_key_next = rd_key;
                    pend_val_next = rd_val;
                    u_s_next = mv_from;
                    u_hoff_next = rd_hoff;
                    u_nx_next = rd_succ;
                    u_pv_next = slot_rdata[7:0];
                    lc_next = mv_c;
                    ls_next = mv_to;
                    lo_next = mv_o;
                    sub_ret_next = S_MV_LINK;
                    state_next = S_UL_HEAD;
                end
            end
            S_MV_LINK:
            begin
                i_next = j_reg;
                sub_ret_next = S_INS_LOOP;
                state_next = S_LK_HEAD;
            end
            S_INS_FIN:
            begin
                lc_next = home_reg;
                ls_next = home_reg + i_reg[AW-1:0];
                lo_next = i_reg[7:0];
                pend_key_next = key_reg;
                pend_val_next = val_reg;
                sub_ret_next = S_INS_OK;
                state_next = S_LK_HEAD;
            end
            S_INS_OK:
            begin
                count_next = count_reg + CW'(1);
                res_status_next = hhm_pkg::STAT_OK;
                res_val_next = val_reg;
                state_next = S_DONE;
            end
            // hand the response to the output register
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_status_next = res_status_reg;
                    out_val_next = 32'(res_val_reg);
                    out_count_next = count_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            sub_ret_reg <= S_IDLE;
            rmw_ret_reg <= S_IDLE;
            clr_cnt_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sub_ret_reg <= sub_ret_next;
            rmw_ret_reg <= rmw_ret_next;
            clr_cnt_reg <= clr_cnt_next;
            count_reg <= count_next;
            out_valid_reg <= out_valid_next;
            out_count_reg <= out_count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_val_reg <= out_val_next;
        op_reg <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        home_reg <= home_next;
        off_reg <= off_next;
        walk_reg <= walk_next;
        f_reg <= f_next;
        fword_reg <= fword_next;
        found_reg <= found_next;
        i_reg <= i_next;
        j_reg <= j_next;
        u_s_reg <= u_s_next;
        u_hoff_reg <= u_hoff_next;
        u_nx_reg <= u_nx_next;
        u_pv_reg <= u_pv_next;
        lc_reg <= lc_next;
        ls_reg <= ls_next;
        lo_reg <= lo_next;
        lsucc_reg <= lsucc_next;
        lpred_reg <= lpred_next;
        q_reg <= q_next;
        pend_key_reg <= pend_key_next;
        pend_val_reg <= pend_val_next;
        rmw_addr_reg <= rmw_addr_next;
        rmw_succ_reg <= rmw_succ_next;
        rmw_val_reg <= rmw_val_next;
        res_status_reg <= res_status_next;
        res_val_reg <= res_val_next;
    end

endmodule

@@ hdl/hopscotch_hash_map.sv @@
// operation: the front hashes the key byte by byte and queues the request, then the back walks the chain
// inserts probe slot by slot for a free one; a link walks the sorted chain to its place
// a move tries slots toward home, then unlinks the moved slot and links it at its new place
// throughput: one request at a time in the back sequencer, the front hashes the next meanwhile
// reset: clearing pass over every slot and head memory entry, no request taken meanwhile
// displacement limit resets to 25, member count to zero
module hopscotch_hash_map #(
    parameter int KEY_BYTES = hhm_pkg::KEY_BYTES_DEF,
    parameter int VALUE_BITS = hhm_pkg::VALUE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [63:0] key,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [31:0] value_out,
    output logic [8:0]  member_count
);

    localparam int QW = 2 + 8 * KEY_BYTES + VALUE_BITS + hhm_pkg::SLOT_W;

    logic [7:0] limit_reg;
    logic [7:0] lim;
    logic clearing;
    logic push_valid, push_ready;
    logic [QW-1:0] push_data;
    logic pop_valid, pop_ready;
    logic [QW-1:0] pop_data;

    // displacement limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= hhm_pkg::LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // saturate the limit into its legal range
    always_comb
    begin
        lim = limit_reg;
        if (limit_reg < hhm_pkg::LIMIT_FLOOR)
        begin
            lim = hhm_pkg::LIMIT_FLOOR;
        end
        else if (limit_reg > hhm_pkg::OFFSET_CEIL)
        begin
            lim = hhm_pkg::OFFSET_CEIL;
        end
    end

    // request intake and hashing
    hhm_front #(
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS),
        .QW         (QW)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .key        (key),
        .value      (value),
        .clearing   (clearing),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // decoupling queue
    hhm_queue #(
        .QW (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // table sequencer
    hhm_back #(
        .KEY_BYTES  (KEY_BYTES),
        .VALUE_BITS (VALUE_BITS),
        .QW         (QW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .lim          (lim),
        .q_valid      (pop_valid),
        .q_pop        (pop_ready),
        .q_data       (pop_data),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value_out    (value_out),
        .member_count (member_count)
    );

`ifndef SYNTHESIS
    // no request is taken during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !in_ready)
        else $error("request accepted during clearing pass");

    // the front end holds one request while hashing
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("front end took a second request while hashing");

    // absent keys and full table report a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == hhm_pkg::STAT_FULL || status == hhm_pkg::STAT_NOT_FOUND)
        |-> value_out == 32'd0)
        else $error("nonzero value with a failing status");

    // member count never exceeds the capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        member_count <= 9'(hhm_pkg::CAPACITY))
        else $error("member count beyond capacity");
`endif

endmodule

@@ tb/sv/tb_hopscotch_hash_map.sv @@
// testbench for the hopscotch hash map: self-checking against a built-in table predictor
`timescale 1ns / 100ps

module tb_hopscotch_hash_map;

    typedef struct packed {
        hhm_pkg::status_t status;
        logic [31:0]      value_out;
        logic [8:0]       member_count;
    } map_reply_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  op;
    logic [63:0] key;
    logic [31:0] value;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [8:0]  member_count;

    // predicted table contents
    bit          pm_used [hhm_pkg::CAPACITY];
    logic [63:0] pm_key [hhm_pkg::CAPACITY];
    logic [31:0] pm_val [hhm_pkg::CAPACITY];
    logic [7:0]  pm_home_ofs [hhm_pkg::CAPACITY];
    logic [7:0]  pm_head [hhm_pkg::CAPACITY];
    logic [7:0]  pm_succ [hhm_pkg::CAPACITY];
    logic [7:0]  pm_pred [hhm_pkg::CAPACITY];
    int          pm_count;
    logic [7:0]  pm_limit;

    map_reply_t  pending_replies[$];
    logic [63:0] key_pool[$];
    int          mismatch_count;
    int          reply_count;
    int          sent_count;
    int          full_count;
    int          present_count;
    int          send_idle_pct;
    int          recv_idle_pct;

    hopscotch_hash_map u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .key          (key),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .value_out    (value_out),
        .member_count (member_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one-at-a-time hash of the eight key bytes, low byte first
    function automatic logic [7:0] home_bucket(input logic [63:0] k);
        logic [31:0] h;
        h = '0;
        for (int n = 0; n < 8; n++)
        begin
            h = h + {24'd0, k[8*n +: 8]};
            h = h + (h << 10);
            h = h ^ (h >> 6);
        end
        h = h + (h << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h[7:0];
    endfunction

    function automatic int chain_lookup(input logic [7:0] hb, input logic [63:0] k);
        logic [7:0] o;
        logic [7:0] s;
        o = pm_head[hb];
        for (int n = 0; n < 256 && o != hhm_pkg::NO_LINK; n++)
        begin
            s = hb + o;
            if (pm_used[s] && pm_key[s] == k)
                return int'(s);
            o = pm_succ[s];
        end
        return -1;
    endfunction

    task automatic chain_unlink(input logic [7:0] s);
        logic [7:0] c;
        logic [7:0] nx;
        logic [7:0] pv;
        c = s - pm_home_ofs[s];
        nx = pm_succ[s];
        pv = pm_pred[s];
        if (pm_head[c] == pm_home_ofs[s])
            pm_head[c] = nx;
        else
            pm_succ[8'(c + pv)] = nx;
        if (nx != hhm_pkg::NO_LINK)
            pm_pred[8'(c + nx)] = pv;
        pm_used[s] = 1'b0;
        pm_home_ofs[s] = hhm_pkg::NO_LINK;
        pm_succ[s] = hhm_pkg::NO_LINK;
        pm_pred[s] = hhm_pkg::NO_LINK;
    endtask

    // sorted insert of offset o into the chain of bucket c
    task automatic chain_link(input logic [7:0] c, input logic [7:0] s, input logic [7:0] o);
        logic [7:0] hd;
        logic [7:0] q;
        int n;
        hd = pm_head[c];
        pm_home_ofs[s] = o;
        if (hd == hhm_pkg::NO_LINK)
        begin
            pm_head[c] = o;
            pm_succ[s] = hhm_pkg::NO_LINK;
            pm_pred[s] = hhm_pkg::NO_LINK;
        end
        else if (o < hd)
        begin
            pm_succ[s] = hd;
            pm_pred[s] = hhm_pkg::NO_LINK;
            pm_pred[8'(c + hd)] = o;
            pm_head[c] = o;
        end
        else
        begin
            q = c + hd;
            n = 0;
            while (pm_succ[q] != hhm_pkg::NO_LINK && pm_succ[q] < o && n < 256)
            begin
                q = c + pm_succ[q];
                n++;
            end
            pm_succ[s] = pm_succ[q];
            pm_pred[s] = pm_home_ofs[q];
            pm_succ[q] = o;
            if (pm_succ[s] != hhm_pkg::NO_LINK)
                pm_pred[8'(c + pm_succ[s])] = o;
        end
    endtask

    task automatic displace(input logic [7:0] src, input logic [7:0] dst, output bit ok);
        logic [7:0] c;
        logic [7:0] o;
        logic [63:0] k;
        logic [31:0] v;
        c = src - pm_home_ofs[src];
        o = dst - c;
        k = pm_key[src];
        v = pm_val[src];
        ok = 1'b0;
        if (o < hhm_pkg::OFFSET_CEIL)
        begin
            chain_unlink(src);
            pm_used[dst] = 1'b1;
            pm_key[dst] = k;
            pm_val[dst] = v;
            chain_link(c, dst, o);
            ok = 1'b1;
        end
    endtask

    // probe for a free slot, then hop it back under the limit
    task automatic place_key(input logic [7:0] hb, input logic [63:0] k, input logic [31:0] v,
                             output bit ok);
        int lim;
        int i;
        bit moved;
        bit mv;
        logic [7:0] s;
        lim = int'(pm_limit);
        if (lim < int'(hhm_pkg::LIMIT_FLOOR)) lim = int'(hhm_pkg::LIMIT_FLOOR);
        if (lim > int'(hhm_pkg::OFFSET_CEIL)) lim = int'(hhm_pkg::OFFSET_CEIL);
        ok = 1'b0;
        for (i = 0; i < hhm_pkg::CAPACITY; i++)
            if (!pm_used[8'(hb + i)])
                break;
        if (i >= hhm_pkg::CAPACITY)
            return;
        while (i >= lim)
        begin
            moved = 1'b0;
            for (int j = i - 1; j >= 0; j--)
            begin
                displace(8'(hb + j), 8'(hb + i), mv);
                if (mv)
                begin
                    i = j;
                    moved = 1'b1;
                    break;
                end
            end
            if (!moved)
                return;
        end
        s = 8'(hb + i);
        pm_used[s] = 1'b1;
        pm_key[s] = k;
        pm_val[s] = v;
        chain_link(hb, s, 8'(i));
        ok = 1'b1;
    endtask

    // apply one request to the predicted table and queue the expected reply
    task automatic predict_request(input hhm_pkg::op_t o, input logic [63:0] k,
                                   input logic [31:0] v);
        logic [7:0] hb;
        int f;
        bit ok;
        map_reply_t r;
        hb = home_bucket(k);
        f = chain_lookup(hb, k);
        r.status = hhm_pkg::STAT_OK;
        r.value_out = '0;
        if (o == hhm_pkg::OP_GET)
        begin
            if (f >= 0) r.value_out = pm_val[f];
            else r.status = hhm_pkg::STAT_NOT_FOUND;
        end
        else if (o == hhm_pkg::OP_REMOVE)
        begin
            if (f >= 0)
            begin
                chain_unlink(8'(f));
                if (pm_count > 0) pm_count--;
            end
            else
                r.status = hhm_pkg::STAT_NOT_FOUND;
        end
        else if (f >= 0)
        begin
            if (o == hhm_pkg::OP_NEW) r.status = hhm_pkg::STAT_PRESENT;
            else pm_val[f] = v;
            r.value_out = pm_val[f];
        end
        else if (pm_count >= hhm_pkg::CAPACITY)
            r.status = hhm_pkg::STAT_FULL;
        else
        begin
            place_key(hb, k, v, ok);
            if (ok)
            begin
                pm_count++;
                r.value_out = v;
            end
            else
                r.status = hhm_pkg::STAT_FULL;
        end
        r.member_count = 9'(pm_count);
        pending_replies.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("mismatch on reply %0d: %s got %0h expected %0h", reply_count, what, got, want);
    endtask

    // send one request; valid stays up into the next call unless a gap is taken
    task automatic send_request(input hhm_pkg::op_t o, input logic [63:0] k,
                                input logic [31:0] v);
        int gap;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct)
            gap = $urandom_range(6, 1);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(o, k, v);
        sent_count++;
    endtask

    task automatic drain_and_idle();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        drain_and_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        pm_limit = v;
        cfg_wr_en <= 1'b0;
    endtask

    // reply checker and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        map_reply_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_replies.size() == 0)
                    report_mismatch("unexpected reply, status", 32'(status), 32'hx);
                else
                begin
                    want = pending_replies.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (value_out !== want.value_out)
                        report_mismatch("value_out", value_out, want.value_out);
                    if (member_count !== want.member_count)
                        report_mismatch("member_count", 32'(member_count),
                                        32'(want.member_count));
                    if (want.status == hhm_pkg::STAT_FULL) full_count++;
                    if (want.status == hhm_pkg::STAT_PRESENT) present_count++;
                end
                reply_count++;
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [63:0] rand_key();
        return {$urandom(), $urandom()};
    endfunction

    // extremes of the fields and each operation on present and absent keys
    task automatic test_directed();
        send_request(hhm_pkg::OP_GET, 64'd0, 32'd0);
        send_request(hhm_pkg::OP_REMOVE, 64'd0, 32'd0);
        send_request(hhm_pkg::OP_PUT, 64'd0, 32'd0);
        send_request(hhm_pkg::OP_NEW, 64'd0, 32'hFFFF_FFFF);
        send_request(hhm_pkg::OP_PUT, 64'd0, 32'hFFFF_FFFF);
        send_request(hhm_pkg::OP_GET, 64'd0, 32'd0);
        send_request(hhm_pkg::OP_NEW, '1, 32'hA5A5_5A5A);
        send_request(hhm_pkg::OP_PUT, '1, 32'h5A5A_A5A5);
        send_request(hhm_pkg::OP_GET, '1, 32'd0);
        send_request(hhm_pkg::OP_REMOVE, '1, '1);
        send_request(hhm_pkg::OP_REMOVE, '1, '1);
        send_request(hhm_pkg::OP_GET, '1, 32'd0);
        send_request(hhm_pkg::OP_NEW, 64'h8000_0000_0000_0001, 32'h8000_0001);
        send_request(hhm_pkg::OP_REMOVE, 64'd0, 32'd0);
        send_request(hhm_pkg::OP_GET, 64'h8000_0000_0000_0001, 32'd0);
        send_request(hhm_pkg::OP_REMOVE, 64'h8000_0000_0000_0001, 32'd0);
    endtask

    // random mix of inserts, lookups and removes weighted by fill_pct, mostly from a reused key pool
    task automatic test_table_churn(input int items, input int fill_pct);
        int pick;
        hhm_pkg::op_t o;
        logic [63:0] k;
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < fill_pct) o = ($urandom_range(1)) ? hhm_pkg::OP_PUT : hhm_pkg::OP_NEW;
            else if (pick < fill_pct + (100 - fill_pct) / 2) o = hhm_pkg::OP_GET;
            else o = hhm_pkg::OP_REMOVE;
            if ($urandom_range(19) == 0) k = rand_key();
            else k = key_pool[$urandom_range(key_pool.size() - 1)];
            send_request(o, k, $urandom());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        op = '0;
        key = '0;
        value = '0;
        mismatch_count = 0;
        reply_count = 0;
        sent_count = 0;
        full_count = 0;
        present_count = 0;
        send_idle_pct = 17;
        recv_idle_pct = 61;
        pm_count = 0;
        pm_limit = hhm_pkg::LIMIT_RESET;
        for (int s = 0; s < hhm_pkg::CAPACITY; s++)
        begin
            pm_used[s] = 1'b0;
            pm_key[s] = '0;
            pm_val[s] = '0;
            pm_home_ofs[s] = hhm_pkg::NO_LINK;
            pm_head[s] = hhm_pkg::NO_LINK;
            pm_succ[s] = hhm_pkg::NO_LINK;
            pm_pred[s] = hhm_pkg::NO_LINK;
        end
        for (int n = 0; n < 330; n++)
            key_pool.push_back(rand_key());
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_table_churn(200, 70);
        write_limit(8'd4);
        test_table_churn(200, 75);
        write_limit(8'd0);
        test_table_churn(100, 40);

        send_idle_pct = 61;
        recv_idle_pct = 17;
        write_limit(8'd255);
        test_table_churn(150, 80);
        write_limit(8'd254);
        test_table_churn(150, 60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(8'($urandom_range(254, 4)));
        test_table_churn(150, 85);
        write_limit(8'd25);
        test_table_churn(150, 30);

        drain_and_idle();
        $display("%0d requests sent, %0d replies checked, %0d full and %0d already present",
                 sent_count, reply_count, full_count, present_count);
        $display("limits covered: reset, 0, 4, 254, 255 and a random value");
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("tb_hopscotch_hash_map passed");
        else
            $display("tb_hopscotch_hash_map failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #500_000_000;
        $display("timeout with %0d replies pending", pending_replies.size());
        $display("tb_hopscotch_hash_map failed");
        $finish;
    end

endmodule

@@ files.f @@
hdl/hhm_pkg.sv
hdl/hhm_ram.sv
hdl/hhm_front.sv
hdl/hhm_queue.sv
hdl/hhm_back.sv
hdl/hopscotch_hash_map.sv
tb/sv/tb_hopscotch_hash_map.sv
